>>> sv/sitda_pkg.sv
// Shared types, constants and helper functions for the signed integer to
// decimal ASCII converter. No dependencies.
package sitda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned DIGITS     = 10;
  localparam int unsigned BCD_W      = 4 * DIGITS;
  localparam int unsigned CONV_STEPS = VALUE_W;
  localparam int unsigned CNT_W      = $clog2(CONV_STEPS);
  localparam int unsigned IDX_W      = $clog2(DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

  // Last step and top digit index, sized to their counters.
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CONV_STEPS - 1);
  localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(DIGITS - 1);

  // One classified transaction: sign and unsigned magnitude.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } back_state_t;

  // One shift-add-3 step: correct every digit of five or more, then shift
  // in the next binary bit.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic             bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // True when every BCD digit is a legal decimal digit.
  function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

>>> sv/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per result
// transaction. Per item the back end runs a load step, the shift-add-3
// steps and then the digit steps, with a minus sign first when negative; it
// starts a new item only after it has emitted the last character of the one
// before. Synchronous active-low reset empties the queue and output and idles.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [VALUE_W-1:0] in_value,
  output logic               empty,
  input  logic               pop,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  item_t q_wr_item;
  item_t q_rd_item;

  // Classify input transactions.
  sitda_front u_front (
    .push     (push),
    .full     (full),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_wr_item)
  );

  // Decouple front and back end.
  sitda_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_item (q_rd_item)
  );

  // Convert and emit characters.
  sitda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (q_rd_item),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

>>> sv/sitda_front.sv
// Front end: accepts input transactions and splits each value into sign and
// magnitude for the queue. Depends on sitda_pkg.
module sitda_front
  import sitda_pkg::*;
(
  input  logic               push,
  output logic               full,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  // Accept whenever the queue has room.
  assign full   = q_full;
  assign q_push = push & ~q_full;

  // Two's complement negate gives the magnitude; the most negative value
  // maps to 2^31, which still fits in the unsigned field.
  assign q_item = '{
    neg: in_value[VALUE_W-1],
    mag: in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value
  };

endmodule

>>> sv/sitda_queue.sv
// Two-entry queue of classified transactions between front and back end.
// Depends on sitda_pkg.
module sitda_queue
  import sitda_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  q_full,
  input  logic  rd_en,
  output logic  q_empty,
  output item_t rd_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign rd_item = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (rd_en) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 2'd1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> sv/sitda_back.sv
// Back end: binary to BCD by shift-add-3, then emits the sign and the digits
// without leading zeros through an output register. Depends on sitda_pkg.
module sitda_back
  import sitda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  back_state_t        state_r, state_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               sign_pend_r, sign_pend_nxt;
  logic               started_r, started_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0]  ochar_r, ochar_nxt;
  logic               olast_r, olast_nxt;

  logic               slot_free;
  logic [3:0]         digit;
  logic               skip_digit;
  logic               emit;

  assign slot_free     = ~ovalid_r | pop;
  assign digit         = bcd_r[{idx_r, 2'b00} +: 4];
  assign skip_digit    = ~started_r & (digit == 4'd0) & (idx_r != '0);
  assign empty         = ~ovalid_r;
  assign out_character = ochar_r;
  assign out_last      = olast_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sign_pend_r && slot_free && idx_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    q_pop         = 1'b0;
    emit          = 1'b0;
    bcd_nxt       = bcd_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    sign_pend_nxt = sign_pend_r;
    started_nxt   = started_r;
    ochar_nxt     = ochar_r;
    olast_nxt     = olast_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          bcd_nxt       = '0;
          bin_nxt       = q_item.mag;
          cnt_nxt       = '0;
          sign_pend_nxt = q_item.neg;
        end
      end
      ST_CONV: begin
        bcd_nxt     = dabble_step(bcd_r, bin_r[VALUE_W-1]);
        bin_nxt     = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt     = cnt_r + CNT_W'(1);
        idx_nxt     = IDX_TOP;
        started_nxt = 1'b0;
      end
      ST_EMIT: begin
        if (sign_pend_r) begin
          if (slot_free) begin
            emit          = 1'b1;
            ochar_nxt     = CHAR_MINUS;
            olast_nxt     = 1'b0;
            sign_pend_nxt = 1'b0;
          end
        end else if (skip_digit) begin
          // Leading zero: step past it without output.
          idx_nxt = idx_r - IDX_W'(1);
        end else if (slot_free) begin
          emit        = 1'b1;
          ochar_nxt   = CHAR_ZERO + {3'b000, digit};
          olast_nxt   = (idx_r == '0);
          started_nxt = 1'b1;
          if (idx_r != '0) begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
    if (emit) begin
      ovalid_nxt = 1'b1;
    end else if (pop) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    bcd_r       <= bcd_nxt;
    bin_r       <= bin_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    sign_pend_r <= sign_pend_nxt;
    started_r   <= started_nxt;
    ochar_r     <= ochar_nxt;
    olast_r     <= olast_nxt;
  end

  // A conversion runs its full number of steps before emission.
  a_conv_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && cnt_r != CNT_LAST) |=> state_r == ST_CONV)
    else $error("conversion left early");

  a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && cnt_r == CNT_LAST) |=> state_r == ST_EMIT)
    else $error("conversion did not end in emission");

  // The queue is drained only between transactions.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && !q_empty))
    else $error("queue popped outside idle");

  // Shift-add-3 leaves only legal decimal digits.
  a_bcd_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> bcd_ok(bcd_r))
    else $error("illegal BCD digit");

  // A new character never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!ovalid_r || pop))
    else $error("output register overwritten");

endmodule

>>> sim/tb_signed_int_to_decimal_ascii.sv
// Self-checking testbench for signed_int_to_decimal_ascii: random and directed
// values in, decimal ASCII characters checked against an in-bench predictor.
// Depends on sitda_pkg and the signed_int_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
  import sitda_pkg::*;

  // One predicted character of a number's text.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } glyph_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [VALUE_W-1:0] in_value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [CHAR_W-1:0]  out_character;
  logic               out_last;

  logic [VALUE_W-1:0] pending_values[$];
  glyph_t             expected_text[$];
  int unsigned        errors = 0;
  int unsigned        chars_seen = 0;
  int unsigned        hold_cycles = 0;
  int unsigned        cycle_no = 0;
  logic               quiet;

  signed_int_to_decimal_ascii dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_value     (in_value),
    .empty        (empty),
    .pop          (pop),
    .out_character(out_character),
    .out_last     (out_last)
  );

  // Free-running clock, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle count; both sides stop idling inside one long window.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end
  assign quiet = (cycle_no >= 3000) && (cycle_no < 6000);

  // Append the decimal text of one value to the expected characters.
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    logic        neg;
    logic [32:0] mag;
    logic [3:0]  digit[DIGITS];
    int          nd;
    neg = v[VALUE_W-1];
    mag = neg ? ({1'b0, ~v} + 33'd1) : {1'b0, v};
    nd = 0;
    do begin
      digit[nd] = 4'(mag % 33'd10);
      mag = mag / 33'd10;
      nd++;
    end while (mag != 0 && nd < DIGITS);
    if (neg) begin
      expected_text.push_back('{ch: CHAR_MINUS, is_last: 1'b0});
    end
    for (int i = nd - 1; i >= 0; i--) begin
      expected_text.push_back('{ch: CHAR_ZERO + CHAR_W'(digit[i]), is_last: (i == 0)});
    end
  endfunction

  // Random value drawn from a mix of shapes: raw bits, random digit counts,
  // neighbors of powers of ten, and neighbors of the two extremes.
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned     kind;
    int unsigned     n;
    longint unsigned p;
    longint unsigned m;
    logic            neg;
    kind = $urandom_range(3);
    neg = 1'($urandom_range(1));
    p = 1;
    case (kind)
      0: begin
        return $urandom();
      end
      1: begin
        n = $urandom_range(1, DIGITS);
        repeat (n) p = p * 10;
        m = {$urandom(), $urandom()} % p;
        if (m > 64'd2147483647) m = m % 64'd2147483648;
      end
      2: begin
        n = $urandom_range(0, DIGITS - 1);
        repeat (n) p = p * 10;
        m = p + $urandom_range(2) - 1;
      end
      default: begin
        m = 64'd2147483647 - $urandom_range(3);
        if (neg && $urandom_range(1)) m = m + 1;
      end
    endcase
    return neg ? VALUE_W'(-m) : VALUE_W'(m);
  endfunction

  // Driver: offer the oldest pending value, predict on each accepted transaction.
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_text(in_value);
        void'(pending_values.pop_front());
      end
      offer = (pending_values.size() != 0) && (quiet || $urandom_range(99) >= 30);
      push <= offer;
      if (offer) begin
        in_value <= pending_values[0];
      end
    end
  end

  // Monitor: compare each accepted character with the oldest expectation.
  // After 120 characters it holds off for a long stretch so the input stalls.
  always @(posedge clk) begin
    glyph_t want;
    logic   take;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %0d last %0b",
                   $time, out_character, out_last);
          errors++;
        end else begin
          want = expected_text.pop_front();
          if (out_character !== want.ch) begin
            $display("%0t: character mismatch: expected %0d, actual %0d",
                     $time, want.ch, out_character);
            errors++;
          end
          if (out_last !== want.is_last) begin
            $display("%0t: last flag mismatch: expected %0b, actual %0b",
                     $time, want.is_last, out_last);
            errors++;
          end
        end
        chars_seen++;
        if (chars_seen == 120) hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        take = 1'b0;
      end else begin
        take = quiet || $urandom_range(99) >= 30;
      end
      pop <= take;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed values: zero, extremes, digit-count boundaries and single bits.
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h8000_0001);
    pending_values.push_back(32'd999_999_999);
    pending_values.push_back(32'd1_000_000_000);
    pending_values.push_back(-32'sd999_999_999);
    pending_values.push_back(-32'sd1_000_000_000);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    pending_values.push_back(32'h4000_0000);
    pending_values.push_back(32'd123_456_789);
    pending_values.push_back(-32'sd9);
    repeat (130) pending_values.push_back(random_value());

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_values.size() != 0 || push);
    do @(negedge clk); while (expected_text.size() != 0);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #400_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
